// ===== rtl/core/rlp_enc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_enc_pkg
// Shared types, constants and the header builder of the RLP item encoder.
// ----------------------------------------------------------------------------
package rlp_enc_pkg;

  localparam logic [7:0]  StrOffset  = 8'h80;
  localparam logic [7:0]  ListOffset = 8'hC0;
  localparam logic [7:0]  LongBase   = 8'd55;
  localparam logic [15:0] ShortLimit = 16'd56;
  localparam logic [15:0] OneByteMax = 16'd256;

  typedef enum logic {
    OpString = 1'b0,
    OpList   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatTooLong = 2'd1,
    StatStray   = 2'd2
  } status_e;

  // one input request
  typedef struct packed {
    op_e         op;
    logic        start;
    logic [15:0] len;
    logic [7:0]  data;
  } item_t;

  // header bytes, count holds the number of bytes minus one
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } header_t;

  // all result bytes caused by one input request
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_e         status;
    logic            end_item;
  } burst_t;

  function automatic header_t make_header(input logic [15:0] len,
                                          input logic [7:0]  offset);
    header_t h;
    h = '0;
    if (len < ShortLimit) begin
      h.count    = 2'd0;
      h.bytes[0] = offset + len[7:0];
    end else if (len < OneByteMax) begin
      h.count    = 2'd1;
      h.bytes[0] = offset + LongBase + 8'd1;
      h.bytes[1] = len[7:0];
    end else begin
      h.count    = 2'd2;
      h.bytes[0] = offset + LongBase + 8'd2;
      h.bytes[1] = len[15:8];
      h.bytes[2] = len[7:0];
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rlp_enc_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_enc_decode
// Turns one input request into its burst of result bytes and keeps the count
// of string payload bytes still owed.
// ----------------------------------------------------------------------------
module rlp_enc_decode
  import rlp_enc_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire item_t  item_i,
  input  wire logic   load_i,
  output burst_t      burst_o
);

  localparam int unsigned RemW = $clog2(MAX_LENGTH);

  logic [RemW-1:0] rem_q, rem_d;
  logic            too_long;
  logic [15:0]     len_m1;
  header_t         hdr;

  assign too_long = {1'b0, item_i.len} >= 17'(MAX_LENGTH);
  assign len_m1   = item_i.len - 16'd1;
  assign hdr      = make_header(item_i.len,
                                (item_i.op == OpList) ? ListOffset : StrOffset);

  always_comb begin
    burst_o = '0;
    burst_o.status = StatOk;
    rem_d = rem_q;
    if (!item_i.start) begin
      if (item_i.op == OpString && rem_q != '0) begin
        burst_o.bytes[0] = item_i.data;
        burst_o.end_item = (rem_q == RemW'(1));
        rem_d            = rem_q - RemW'(1);
      end else begin
        burst_o.status = StatStray;
      end
    end else if (too_long) begin
      burst_o.status = StatTooLong;
      rem_d          = '0;
    end else if (item_i.op == OpList) begin
      burst_o.bytes[2:0] = hdr.bytes;
      burst_o.last_idx   = hdr.count;
      burst_o.end_item   = 1'b1;
      rem_d              = '0;
    end else if (item_i.len == 16'd1 && !item_i.data[7]) begin
      // single small byte goes out alone, zero is sent as the empty string
      burst_o.bytes[0] = (item_i.data == 8'd0) ? StrOffset : item_i.data;
      burst_o.end_item = 1'b1;
      rem_d            = '0;
    end else if (item_i.len == 16'd0) begin
      burst_o.bytes[0] = StrOffset;
      burst_o.end_item = 1'b1;
      rem_d            = '0;
    end else begin
      burst_o.bytes[2:0]                = hdr.bytes;
      burst_o.bytes[hdr.count + 2'd1]   = item_i.data;
      burst_o.last_idx                  = hdr.count + 2'd1;
      burst_o.end_item                  = (item_i.len == 16'd1);
      rem_d                             = len_m1[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= rem_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rlp_enc_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_enc_serial
// Result register that holds one burst and hands its bytes out one per beat.
// ----------------------------------------------------------------------------
module rlp_enc_serial
  import rlp_enc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire burst_t burst_i,
  input  wire logic   load_i,
  output logic        can_load_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic [7:0]  byte_o,
  output status_e     status_o,
  output logic        last_o,
  output logic        end_o
);

  burst_t     burst_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last_beat;

  assign last_beat  = (idx_q == burst_q.last_idx);
  assign can_load_o = !valid_q || (ready_i && last_beat);

  assign valid_o  = valid_q;
  assign byte_o   = burst_q.bytes[idx_q];
  assign status_o = burst_q.status;
  assign last_o   = last_beat;
  assign end_o    = last_beat && burst_q.end_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (valid_q && ready_i) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rlp_item_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_item_encoder
// Byte-serial RLP encoder for strings and list headers.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the operation and the
// start flag, tdata the item length and a payload byte. The first request of
// a string carries its length and first byte, later requests carry one byte
// each; a list request carries only the length. Encoded bytes leave on the
// m_axis channel with status and end-of-item in tuser and tlast marking the
// final byte caused by a request.
// A request sits in an input register, is decoded into its full burst of up
// to four bytes and loaded into the result register; the first byte is valid
// on m_axis once the burst is in the result register. A request causing one
// byte (every payload byte) sustains one per cycle while m_axis_tready is high;
// a request causing n bytes holds the input side while the result register
// drains. When the receiver stalls, the result register holds, the input
// register fills and s_axis_tready falls. Reset empties both registers and
// clears the count of payload bytes owed.
// ----------------------------------------------------------------------------
module rlp_item_encoder
  import rlp_enc_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // item_length[15:0], data_byte[23:16]
  input  wire logic [1:0]  s_axis_tuser_i,  // operation[0], start_of_item[1]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // out_byte[7:0]
  output logic [2:0]       m_axis_tuser_o,  // status[1:0], end_of_item[2]
  output logic             m_axis_tlast_o   // last_of_run
);

  item_t   item_q;
  logic    item_valid_q;
  logic    can_load;
  logic    load;
  burst_t  burst;
  status_e status;
  logic    end_item;

  assign s_axis_tready_o = !item_valid_q || can_load;
  assign load            = item_valid_q && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_valid_q <= 1'b1;
    end else if (load) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q.op    <= op_e'(s_axis_tuser_i[0]);
      item_q.start <= s_axis_tuser_i[1];
      item_q.len   <= s_axis_tdata_i[15:0];
      item_q.data  <= s_axis_tdata_i[23:16];
    end
  end

  rlp_enc_decode #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_q),
    .load_i (load),
    .burst_o(burst)
  );

  rlp_enc_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .burst_i   (burst),
    .load_i    (load),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .byte_o    (m_axis_tdata_o),
    .status_o  (status),
    .last_o    (m_axis_tlast_o),
    .end_o     (end_item)
  );

  assign m_axis_tuser_o = {end_item, status};

  // error results are single zero bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status != StatOk |-> m_axis_tdata_o == 8'd0 && m_axis_tlast_o)
    else $error("error result is not a lone zero byte");

  // an item only completes on the final byte of a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && end_item |-> m_axis_tlast_o && status == StatOk)
    else $error("end of item off the final byte");

  // a request waiting in the input register is neither lost nor altered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !load |=> item_valid_q && $stable(item_q))
    else $error("pending request dropped");

endmodule
`default_nettype wire
